@@ rtl/rci_pkg.sv @@
`default_nettype none
package rci_pkg;

  localparam int H_W = 66;  // dir . o, signed
  localparam int A_W = 64;  // |dir|^2, unsigned
  localparam int C_W = 68;  // |o|^2 - r^2, signed
  localparam int QDEPTH = 8;
  localparam int QCNT_W = 4;
  localparam int QPTR_W = 3;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  typedef struct packed {
    logic                  skip;
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
    logic signed [C_W-1:0] c;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLASS,
    ST_SQRT,
    ST_PICK,
    ST_DIV_CHK,
    ST_DIV
  } back_state_t;

endpackage
`default_nettype wire

@@ rtl/rci_front.sv @@
`default_nettype none
module rci_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  input  wire logic signed [31:0] dir_x,
  input  wire logic signed [31:0] dir_y,
  input  wire logic [30:0]        max_distance,
  input  wire logic signed [31:0] center_x,
  input  wire logic signed [31:0] center_y,
  input  wire logic [30:0]        radius,
  output logic [1:0]              inflight,
  output logic                    push,
  output rci_pkg::item_t          item
);
  import rci_pkg::*;

  logic               v0, v1, v2;
  logic signed [32:0] ox, oy;
  logic signed [31:0] dx0, dy0;
  logic [30:0]        r0, m0;
  logic signed [65:0] oxx, oyy, hx, hy;
  logic [63:0]        dxx, dyy, lim;
  logic [61:0]        rr;
  logic [31:0]        rm;
  logic [66:0]        d2;

  assign rm = {1'b0, r0} + {1'b0, m0};
  assign d2 = {1'b0, oxx} + {1'b0, oyy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
    end
  end

  // stage 0: offset from the axis
  always_ff @(posedge clk) begin
    ox  <= $signed({origin_x[31], origin_x}) - $signed({center_x[31], center_x});
    oy  <= $signed({origin_y[31], origin_y}) - $signed({center_y[31], center_y});
    dx0 <= dir_x;
    dy0 <= dir_y;
    r0  <= radius;
    m0  <= max_distance;
  end

  // stage 1: products, none wider than 33 by 33
  always_ff @(posedge clk) begin
    oxx <= ox * ox;
    oyy <= oy * oy;
    dxx <= 64'(dx0 * dx0);
    dyy <= 64'(dy0 * dy0);
    hx  <= dx0 * ox;
    hy  <= dy0 * oy;
    rr  <= r0 * r0;
    lim <= rm * rm;
  end

  // stage 2: sums and early-out classification
  always_ff @(posedge clk) begin
    item.a    <= dxx + dyy;
    item.h    <= hx + hy;
    item.c    <= $signed({1'b0, d2}) - $signed({6'd0, rr});
    item.skip <= (d2 > {3'd0, lim}) || ((dxx + dyy) == '0);
  end

  assign push     = v2;
  assign inflight = 2'({1'b0, v0} + {1'b0, v1} + {1'b0, v2});

endmodule
`default_nettype wire

@@ rtl/rci_queue.sv @@
`default_nettype none
module rci_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rci_pkg::item_t  wr_item,
  input  wire logic            pop,
  output rci_pkg::item_t       rd_item,
  output logic                 empty,
  output logic [rci_pkg::QCNT_W-1:0] count
);
  import rci_pkg::*;

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign empty   = (count == '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_item;
  end

endmodule
`default_nettype wire

@@ rtl/rci_back.sv @@
`default_nettype none
module rci_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  input  wire rci_pkg::item_t head,
  output logic                pop,
  output logic                done,
  output logic                hit,
  output logic [30:0]         distance
);
  import rci_pkg::*;

  localparam int DEL_W = 134;
  localparam int RAD_W = 132;
  localparam int DW    = 96 + FRAC_BITS;

  back_state_t state, state_next;

  logic [6:0]             cnt;
  logic [64:0]            hbits;
  logic [66:0]            cbits;
  logic [DEL_W-1:0]       mh, ma;
  logic signed [DEL_W-1:0] acc;
  logic signed [H_W-1:0]  h;
  logic [A_W-1:0]         a;
  logic                   hneg, cneg, cpos;
  logic [RAD_W-1:0]       rad;
  logic [68:0]            rem;
  logic [65:0]            root;
  logic [66:0]            num;
  logic [DW-1:0]          rdiv, ds;
  logic [30:0]            q;

  logic [68:0]            rem2, trial;
  logic signed [67:0]     nh, num_near, num_far;
  logic [DW-1:0]          nfull, asat;
  logic signed [DEL_W-1:0] acc_add;

  assign rem2     = {rem[66:0], rad[RAD_W-1 -: 2]};
  assign trial    = {1'b0, root, 2'b01};
  assign nh       = -($signed({{2{h[H_W-1]}}, h}));
  assign num_near = nh - $signed({2'b0, root});
  assign num_far  = nh + $signed({2'b0, root});
  assign nfull    = DW'({num, {FRAC_BITS{1'b0}}});
  assign asat     = DW'({a, 31'd0});
  assign acc_add  = (hbits[0] ? $signed(mh) : '0)
                  + (cbits[0] ? (cneg ? $signed(ma) : -$signed(ma)) : '0);

  assign pop = (state == ST_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (pop && !head.skip) state_next = ST_MUL;
      ST_MUL:     if (cnt == 7'd66) state_next = ST_CLASS;
      ST_CLASS: begin
        if (acc == '0) state_next = hneg ? ST_DIV_CHK : ST_IDLE;
        else if (acc[DEL_W-1]) state_next = ST_IDLE;
        else state_next = ST_SQRT;
      end
      ST_SQRT:    if (cnt == 7'd65) state_next = ST_PICK;
      ST_PICK:    state_next = (hneg || cneg) ? ST_DIV_CHK : ST_IDLE;
      ST_DIV_CHK: state_next = (nfull >= asat) ? ST_IDLE : ST_DIV;
      ST_DIV:     if (cnt == 7'd30) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE:    if (pop && head.skip) done <= 1'b1;
        ST_CLASS:   if (acc[DEL_W-1] || (acc == '0 && !hneg)) done <= 1'b1;
        ST_PICK:    if (!(hneg || cneg)) done <= 1'b1;
        ST_DIV_CHK: if (nfull >= asat) done <= 1'b1;
        ST_DIV:     if (cnt == 7'd30) done <= 1'b1;
        default:    done <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // latch the beat and seed the serial product h*h - a*c
        h        <= head.h;
        a        <= head.a;
        hneg     <= head.h[H_W-1];
        cneg     <= head.c[C_W-1];
        cpos     <= !head.c[C_W-1] && (head.c != '0);
        hbits    <= head.h[H_W-1] ? 65'(-head.h) : head.h[64:0];
        cbits    <= head.c[C_W-1] ? 67'(-head.c) : head.c[66:0];
        mh       <= DEL_W'(head.h[H_W-1] ? 65'(-head.h) : head.h[64:0]);
        ma       <= DEL_W'(head.a);
        acc      <= '0;
        cnt      <= '0;
        hit      <= 1'b0;
        distance <= '0;
      end
      ST_MUL: begin
        acc   <= acc + acc_add;
        mh    <= {mh[DEL_W-2:0], 1'b0};
        ma    <= {ma[DEL_W-2:0], 1'b0};
        hbits <= {1'b0, hbits[64:1]};
        cbits <= {1'b0, cbits[66:1]};
        cnt   <= cnt + 1'b1;
      end
      ST_CLASS: begin
        rad  <= acc[RAD_W-1:0];
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        num  <= nh[66:0];
      end
      ST_SQRT: begin
        // two radicand bits a step
        rad <= {rad[RAD_W-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (rem2 >= trial) begin
          rem  <= rem2 - trial;
          root <= {root[64:0], 1'b1};
        end else begin
          rem  <= rem2;
          root <= {root[64:0], 1'b0};
        end
      end
      ST_PICK: num <= (hneg && cpos) ? num_near[66:0] : num_far[66:0];
      ST_DIV_CHK: begin
        rdiv <= nfull;
        ds   <= DW'({a, 30'd0});
        q    <= '0;
        cnt  <= '0;
        if (nfull >= asat) begin
          hit      <= 1'b1;
          distance <= '1;
        end
      end
      ST_DIV: begin
        cnt <= cnt + 1'b1;
        ds  <= {1'b0, ds[DW-1:1]};
        if (rdiv >= ds) begin
          rdiv <= rdiv - ds;
          q    <= {q[29:0], 1'b1};
        end else begin
          q    <= {q[29:0], 1'b0};
        end
        if (cnt == 7'd30) begin
          hit      <= 1'b1;
          distance <= {q[29:0], rdiv >= ds};
        end
      end
      default: cnt <= cnt;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/ray_cylinder_intersection.sv @@
// Result paths with an empty queue: a ray cut by the early-out or a zero direction is
// done as it leaves the queue; a miss is found from the discriminant or after the root; a hit
// ends at the saturation check (tangent, saturated t) or after the full divide (two roots).
// Throughput: while busy is low the front takes one ray a cycle into an 8-beat queue; the back
// works one ray at a time through a bit-serial product, a two-bit-a-step root
// and a one-bit-a-step divide, and that shared unit sets the sustained rate.
`default_nettype none
module ray_cylinder_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  input  wire logic signed [31:0] dir_x,
  input  wire logic signed [31:0] dir_y,
  input  wire logic [30:0]        max_distance,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    done,
  output logic                    hit,
  output logic [30:0]             distance
);
  import rci_pkg::*;

  // Reset (rst, synchronous): empty pipeline and queue; centre 0, radius 1.0.
  logic signed [31:0] center_x, center_y;
  logic [30:0]        radius;
  logic               accept, push, pop, empty;
  logic [1:0]         inflight;
  logic [QCNT_W-1:0]  count;
  item_t              f_item, q_item;

  // always take config writes; write them only while idle, which the block itself does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius   <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_RADIUS:   radius   <= cfg_data[30:0];
        default:      radius   <= radius;
      endcase
    end
  end

  // hold off new rays once every queue slot is spoken for by beats in flight
  assign busy   = ({1'b0, count} + {3'd0, inflight}) >= (QCNT_W+1)'(QDEPTH);
  assign accept = start && !busy;

  rci_front u_front (
    .clk, .rst, .accept,
    .origin_x, .origin_y, .dir_x, .dir_y, .max_distance,
    .center_x, .center_y, .radius,
    .inflight, .push, .item(f_item)
  );

  rci_queue u_queue (
    .clk, .rst, .push, .wr_item(f_item), .pop,
    .rd_item(q_item), .empty, .count
  );

  rci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .empty, .head(q_item), .pop,
    .done, .hit, .distance
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCNT_W'(QDEPTH) || pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("queue underflow");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (distance == '0)) else $error("miss with nonzero distance");
`endif

endmodule
`default_nettype wire

@@ sim/ray_cylinder_intersection_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ray_cylinder_intersection_tb;
  import rci_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RAND_PER_PHASE = 250;
  localparam int FRAC_BITS = 16;
  localparam logic [30:0] DIST_SAT = 31'h7FFF_FFFF;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [31:0] origin_x = '0;
  logic signed [31:0] origin_y = '0;
  logic signed [31:0] dir_x = '0;
  logic signed [31:0] dir_y = '0;
  logic [30:0]        max_distance = '0;
  logic               cfg_valid = 1'b0;
  logic [1:0]         cfg_index = REG_CENTER_X;
  logic [31:0]        cfg_data = '0;
  logic               busy, cfg_ready, done, hit;
  logic [30:0]        distance;

  ray_cylinder_intersection #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .origin_x(origin_x), .origin_y(origin_y), .dir_x(dir_x), .dir_y(dir_y),
    .max_distance(max_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done), .hit(hit), .distance(distance)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic        hit;
    logic [30:0] span;
  } crossing_t;

  typedef struct {
    logic signed [31:0] ox, oy, dx, dy;
    logic [30:0]        md;
    logic               typed;
    crossing_t          want;
  } ray_row_t;

  // shadow of the cylinder registers, kept in step with our own writes
  logic signed [31:0] axis_x = '0;
  logic signed [31:0] axis_y = '0;
  logic [30:0]        cyl_radius = 31'd65536;

  crossing_t crossings_due[$];
  logic      row_typed = 1'b0;
  crossing_t row_want = '0;
  int        errors = 0;
  int        rays_sent = 0;
  int        hits_seen = 0;
  int        results_seen = 0;
  int        cycles = 0;

  // First positive crossing of the ray with the circle, worked exactly in 160 bits
  function automatic crossing_t first_crossing(input logic signed [31:0] px, py, vx, vy,
                                               input logic [30:0] md);
    logic signed [159:0] ox, oy, dx, dy, r, m, d2, lim, a, h, c, disc, root, cand, num;
    logic [159:0] q;
    crossing_t res;
    ox = px; ox = ox - axis_x;
    oy = py; oy = oy - axis_y;
    dx = vx;
    dy = vy;
    r = {129'd0, cyl_radius};
    m = {129'd0, md};
    res = '0;
    d2 = ox * ox + oy * oy;
    lim = (r + m) * (r + m);
    if (d2 > lim) return res;             // origin too far outside the wall
    a = dx * dx + dy * dy;
    if (a == 0) return res;               // no planar direction
    h = dx * ox + dy * oy;
    c = d2 - r * r;
    disc = h * h - a * c;
    if (disc == 0) begin
      if (h >= 0) return res;             // grazing behind the origin
      num = -h;
    end else if (disc < 0) begin
      return res;
    end else begin
      root = '0;
      for (int i = 69; i >= 0; i--) begin
        cand = root | (160'sd1 <<< i);
        if (cand * cand <= disc) root = cand;
      end
      if (h < 0 && c > 0) num = -h - root;
      else if (h < 0 || c < 0) num = -h + root;
      else return res;
    end
    q = $unsigned(num <<< FRAC_BITS) / $unsigned(a);
    res.hit = 1'b1;
    res.span = (q > 160'h7FFF_FFFF) ? DIST_SAT : q[30:0];
    return res;
  endfunction

  // take a beat: the expectation is queued on the edge the block accepts the ray
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      crossings_due.push_back(row_typed ? row_want
          : first_crossing(origin_x, origin_y, dir_x, dir_y, max_distance));
      rays_sent++;
    end
  end

  // results cannot be held off, so check every strobe as it passes
  always @(posedge clk) begin
    crossing_t exp_c;
    if (!rst && done) begin
      results_seen++;
      if (hit) hits_seen++;
      if (crossings_due.size() == 0) begin
        $display("%0t: result with nothing outstanding, hit %0b distance %0d",
                 $time, hit, distance);
        errors++;
      end else begin
        exp_c = crossings_due.pop_front();
        if (hit !== exp_c.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_c.hit, hit);
          errors++;
        end
        if (distance !== exp_c.span) begin
          $display("%0t: distance expected %0d actual %0d", $time, exp_c.span, distance);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, crossings_due.size());
      $display("ray_cylinder_intersection test failed");
      $finish;
    end
  end

  // present one ray and hold it until the block takes the beat
  task automatic send_ray(input ray_row_t row);
    @(negedge clk);
    origin_x <= row.ox;
    origin_y <= row.oy;
    dir_x <= row.dx;
    dir_y <= row.dy;
    max_distance <= row.md;
    row_typed <= row.typed;
    row_want <= row.want;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTER_X: axis_x = val;
      REG_CENTER_Y: axis_y = val;
      default:      cyl_radius = val[30:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain before touching the registers so every ray sees one setting
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (crossings_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic ray_row_t mk(input logic signed [31:0] ox, oy, dx, dy,
                                  input logic [30:0] md, input logic typed,
                                  input logic h, input logic [30:0] d);
    ray_row_t row;
    row.ox = ox; row.oy = oy; row.dx = dx; row.dy = dy; row.md = md;
    row.typed = typed;
    row.want.hit = h;
    row.want.span = d;
    return row;
  endfunction

  // well-formed rays aimed near the cylinder, plus a share of raw noise
  function automatic ray_row_t random_ray();
    ray_row_t row;
    int sh;
    int kind;
    row.typed = 1'b0;
    row.want = '0;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      row.ox = $urandom; row.oy = $urandom; row.dx = $urandom; row.dy = $urandom;
      row.md = 31'($urandom);
    end else begin
      sh = $urandom_range(0, 14);
      row.ox = axis_x + ($signed($urandom) >>> (14 + sh));
      row.oy = axis_y + ($signed($urandom) >>> (14 + sh));
      sh = $urandom_range(0, 30);
      row.dx = $signed($urandom) >>> sh;
      row.dy = $signed($urandom) >>> $urandom_range(0, 30);
      if (kind == 2) row.dy = '0;
      if (kind == 3) row.dx = '0;
      row.md = ($urandom_range(0, 2) == 0) ? 31'($urandom >> $urandom_range(0, 31))
                                           : DIST_SAT;
    end
    return row;
  endfunction

  ray_row_t directed[$];
  logic [31:0] phase_cx[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000, 32'hFFFE_0000};
  logic [31:0] phase_cy[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_4000, 32'h0000_0000};
  logic [31:0] phase_r[4]  = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0100, 32'h0003_0000};

  initial begin
    int burst;
    // default cylinder: axis at the origin, radius 1.0
    directed.push_back(mk(0, 0, 0, 0, 0, 1, 0, 0));                       // no direction
    directed.push_back(mk(32'h000A_0000, 0, 32'h0001_0000, 0, 0, 1, 0, 0)); // early out
    directed.push_back(mk(0, 0, 32'h0001_0000, 0, 0, 1, 1, 31'd65536));     // from inside
    directed.push_back(mk(32'hFFFE_0000, 0, 32'h0001_0000, 0, DIST_SAT, 1, 1, 31'd65536));
    directed.push_back(mk(32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000, 0, DIST_SAT,
                          1, 1, 31'd131072));                              // tangent
    directed.push_back(mk(32'h0002_0000, 0, 32'h0001_0000, 0, DIST_SAT, 1, 0, 0));
    directed.push_back(mk(32'h8000_0000, 0, 1, 0, DIST_SAT, 1, 1, DIST_SAT)); // saturates
    directed.push_back(mk(32'h0002_0000, 0, 32'hFFFF_0000, 0, DIST_SAT, 0, 0, 0));
    directed.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          DIST_SAT, 0, 0, 0));
    directed.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          DIST_SAT, 0, 0, 0));
    directed.push_back(mk(32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
    directed.push_back(mk(0, 32'h0000_8000, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 0));
    directed.push_back(mk(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 0)); // on the wall
    directed.push_back(mk(0, 32'hFFFE_0000, 0, 32'h7FFF_FFFF, 31'd1, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_ray(directed[i]);

    // phase 0 keeps reset values, later phases move the axis and radius
    for (int ph = 0; ph <= 4; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(REG_CENTER_X, phase_cx[ph-1]);
        write_reg(REG_CENTER_Y, phase_cy[ph-1]);
        write_reg(REG_RADIUS, phase_r[ph-1]);
      end
      for (int n = 0; n < RAND_PER_PHASE; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < RAND_PER_PHASE; b++, n++) send_ray(random_ray());
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 30));
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (crossings_due.size() != 0) begin
      $display("%0d expected results never arrived", crossings_due.size());
      errors++;
    end
    $display("%0d rays over 5 cylinder settings, %0d results, %0d hits, %0d errors",
             rays_sent, results_seen, hits_seen, errors);
    if (errors == 0) begin
      $display("ray_cylinder_intersection test passed");
    end else begin
      $display("ray_cylinder_intersection test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ ray_cylinder_intersection.f @@
rtl/rci_pkg.sv
rtl/rci_front.sv
rtl/rci_queue.sv
rtl/rci_back.sv
rtl/ray_cylinder_intersection.sv
sim/ray_cylinder_intersection_tb.sv
